// ===== src/p16cpu_pkg.sv =====
// shared types and constants for the predicated 16-bit cpu core
// no dependencies
package p16cpu_pkg;

  typedef enum logic [1:0] {
    OP_EXEC    = 2'd0,
    OP_LDRET   = 2'd1,
    OP_IRQ     = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_t;

  localparam logic [3:0] OPC_MOV  = 4'd0;
  localparam logic [3:0] OPC_AND  = 4'd1;
  localparam logic [3:0] OPC_OR   = 4'd2;
  localparam logic [3:0] OPC_XOR  = 4'd3;
  localparam logic [3:0] OPC_ADD  = 4'd4;
  localparam logic [3:0] OPC_ADC  = 4'd5;
  localparam logic [3:0] OPC_STO  = 4'd6;
  localparam logic [3:0] OPC_LD   = 4'd7;
  localparam logic [3:0] OPC_ROR  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_SUB  = 4'd10;
  localparam logic [3:0] OPC_SBC  = 4'd11;
  localparam logic [3:0] OPC_CMP  = 4'd12;
  localparam logic [3:0] OPC_CMPC = 4'd13;
  localparam logic [3:0] OPC_BSWP = 4'd14;
  localparam logic [3:0] OPC_PSR  = 4'd15;

  localparam logic [2:0] PRED_ALWAYS = 3'd0;
  localparam logic [2:0] PRED_NEVER  = 3'd1;
  localparam logic [2:0] PRED_Z      = 3'd2;
  localparam logic [2:0] PRED_NZ     = 3'd3;
  localparam logic [2:0] PRED_C      = 3'd4;
  localparam logic [2:0] PRED_NC     = 3'd5;
  localparam logic [2:0] PRED_S      = 3'd6;
  localparam logic [2:0] PRED_NS     = 3'd7;

  localparam logic [3:0] REG_ZERO = 4'd0;
  localparam logic [3:0] REG_PC   = 4'd15;

  localparam int FLAG_Z_BIT  = 0;
  localparam int FLAG_C_BIT  = 1;
  localparam int FLAG_S_BIT  = 2;
  localparam int FLAG_EI_BIT = 3;
  localparam logic [7:0] SOFT_IRQ_BITS = 8'hF0;

  localparam logic CFG_RESET_VEC = 1'b0;
  localparam logic CFG_IRQ_VEC   = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] instruction_word;
    logic [15:0] operand_word;
    logic [15:0] load_data;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [15:0] access_address;
    logic [15:0] write_data;
    logic [15:0] next_fetch_address;
    logic [7:0]  status_word;
    logic        awaiting_load;
  } out_beat_t;

  // one architectural update computed by the execute logic
  typedef struct packed {
    logic        reg_we;
    logic [3:0]  reg_idx;
    logic [15:0] reg_val;
    logic [15:0] pc;
    logic [7:0]  flags;
    logic        save_we;
    logic [15:0] save_pc;
    logic [7:0]  save_st;
    logic [4:0]  pend;
    logic        restart;
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] wdata;
  } upd_t;

endpackage

// ===== src/p16cpu_exec.sv =====
// combinational execute logic: one item against current architectural state
// depends on p16cpu_pkg
module p16cpu_exec import p16cpu_pkg::*; (
  input  in_beat_t    item,
  input  logic [15:0] rd_src,
  input  logic [15:0] rd_dst,
  input  logic [15:0] pc,
  input  logic [7:0]  flags,
  input  logic [15:0] ret_pc,
  input  logic [7:0]  saved_st,
  input  logic [4:0]  pend,
  input  logic [15:0] irq_vec,
  output upd_t        upd
);

  logic [2:0]  pred;
  logic        len;
  logic [3:0]  opc;
  logic [3:0]  src;
  logic [3:0]  dst;
  logic        holds;
  logic        cin;
  logic [15:0] pc_inc;
  logic [15:0] src_val;
  logic [15:0] dst_val;
  logic [15:0] ea;
  logic [16:0] sum;
  logic [15:0] res;
  logic        cout;
  logic        keep;
  logic        wr;
  logic [3:0]  tgt;
  logic [7:0]  psr_val;

  assign pred = item.instruction_word[15:13];
  assign len  = item.instruction_word[12];
  assign opc  = item.instruction_word[11:8];
  assign src  = item.instruction_word[7:4];
  assign dst  = item.instruction_word[3:0];
  assign cin  = flags[FLAG_C_BIT];
  assign pc_inc = pc + (len ? 16'd2 : 16'd1);
  // r15 as an operand reads the already advanced pc
  assign src_val = (src == REG_PC) ? pc_inc : rd_src;
  assign dst_val = (dst == REG_PC) ? pc_inc : rd_dst;
  assign ea = src_val + (len ? item.operand_word : 16'd0);
  assign psr_val = ea[7:0];

  // predicate check
  always_comb begin
    case (pred)
      PRED_ALWAYS: holds = 1'b1;
      PRED_NEVER:  holds = 1'b0;
      PRED_Z:      holds = flags[FLAG_Z_BIT];
      PRED_NZ:     holds = ~flags[FLAG_Z_BIT];
      PRED_C:      holds = flags[FLAG_C_BIT];
      PRED_NC:     holds = ~flags[FLAG_C_BIT];
      PRED_S:      holds = flags[FLAG_S_BIT];
      default:     holds = ~flags[FLAG_S_BIT];
    endcase
  end

  // shared adder for add, adc, sub, sbc and compares
  always_comb begin
    case (opc)
      OPC_ADD:  sum = {1'b0, dst_val} + {1'b0, ea};
      OPC_ADC:  sum = {1'b0, dst_val} + {1'b0, ea} + {16'd0, cin};
      OPC_SBC,
      OPC_CMPC: sum = {1'b0, dst_val} + {1'b0, ~ea} + {16'd0, cin};
      default:  sum = {1'b0, dst_val} + {1'b0, ~ea} + 17'd1;
    endcase
  end

  // result select
  always_comb begin
    res  = 16'd0;
    cout = cin;
    keep = 1'b0;
    wr   = 1'b1;
    tgt  = dst;
    case (opc)
      OPC_MOV:  res = ea;
      OPC_AND:  res = dst_val & ea;
      OPC_OR:   res = dst_val | ea;
      OPC_XOR:  res = dst_val ^ ea;
      OPC_ADD, OPC_ADC, OPC_SUB, OPC_SBC: begin
        res = sum[15:0]; cout = sum[16];
      end
      OPC_CMP, OPC_CMPC: begin
        res = sum[15:0]; cout = sum[16]; tgt = REG_ZERO;
      end
      OPC_STO, OPC_LD: begin
        keep = 1'b1; wr = 1'b0;
      end
      OPC_ROR: begin
        res = {cin, ea[15:1]}; cout = ea[0];
      end
      OPC_NOT:  res = ~ea;
      OPC_BSWP: res = {ea[7:0], ea[15:8]};
      default: begin
        if (dst == REG_PC || dst == REG_ZERO) begin
          keep = 1'b1; wr = 1'b0;
        end else if (src == REG_ZERO) begin
          res = {8'd0, flags};
        end else begin
          res = dst_val; wr = 1'b0;
        end
      end
    endcase
  end

  // state update
  always_comb begin
    upd = '0;
    upd.pc      = pc;
    upd.flags   = flags;
    upd.pend    = pend;
    upd.save_pc = pc;
    upd.save_st = flags & ~SOFT_IRQ_BITS;
    upd.reg_idx = tgt;
    upd.reg_val = res;
    case (item.operation)
      OP_RESTART: upd.restart = 1'b1;
      OP_LDRET: begin
        if (pend[4]) begin
          upd.reg_idx = pend[3:0];
          upd.reg_val = item.load_data;
          upd.reg_we  = 1'b1;
          upd.pend    = 5'd0;
          if (pend[3:0] == REG_PC) begin
            upd.pc = item.load_data;
          end else begin
            upd.flags[FLAG_S_BIT] = item.load_data[15];
            upd.flags[FLAG_Z_BIT] = (item.load_data == 16'd0);
          end
        end
      end
      OP_IRQ: begin
        if (!pend[4] && flags[FLAG_EI_BIT]) begin
          upd.save_we = 1'b1;
          upd.pc = irq_vec;
          upd.flags[FLAG_EI_BIT] = 1'b0;
        end
      end
      default: begin
        if (!pend[4]) begin
          upd.pc = pc_inc;
          if (holds) begin
            if (opc == OPC_STO) begin
              upd.kind = ACC_WRITE; upd.addr = ea; upd.wdata = dst_val;
            end
            if (opc == OPC_LD) begin
              upd.kind = ACC_READ; upd.addr = ea; upd.pend = {1'b1, dst};
            end
            if (opc == OPC_PSR && dst == REG_PC) begin
              upd.pc = ret_pc;
              upd.flags = saved_st & ~SOFT_IRQ_BITS;
            end else if (opc == OPC_PSR && dst == REG_ZERO) begin
              upd.flags = psr_val;
              if ((psr_val & SOFT_IRQ_BITS) != 8'd0) begin
                upd.save_we = 1'b1;
                upd.save_pc = pc_inc;
                upd.save_st = psr_val & ~SOFT_IRQ_BITS;
                upd.pc = irq_vec;
                upd.flags[FLAG_EI_BIT] = 1'b0;
              end
            end
            if (wr && tgt != REG_ZERO) begin
              upd.reg_we = 1'b1;
              if (tgt == REG_PC) upd.pc = res;
            end
            if (!keep && tgt != REG_PC) begin
              upd.flags[FLAG_S_BIT] = res[15];
              upd.flags[FLAG_Z_BIT] = (res == 16'd0);
              upd.flags[FLAG_C_BIT] = cout;
            end
          end
        end
      end
    endcase
  end

endmodule

// ===== src/predicated_16bit_cpu_core_unit.sv =====
// the result beat is registered at the accept edge; throughput: one item per
// cycle unless in_stall; state is updated at the accept edge so the next item
// sees it at once; the output register holds while stalled
// reset (rst_n low, synchronous): registers zero, pc = 0, vectors zero
// restart item reloads pc from reset_vector and keeps the vectors
// top level of the predicated 16-bit cpu core, depends on p16cpu_pkg, p16cpu_exec
module predicated_16bit_cpu_core_unit import p16cpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] regs_r [1:15];
  logic [7:0]  flags_r;
  logic [15:0] ret_pc_r;
  logic [7:0]  saved_st_r;
  logic [4:0]  pend_r;
  logic [15:0] rst_vec_r;
  logic [15:0] irq_vec_r;
  logic        out_valid_r;
  out_beat_t   out_r;
  out_beat_t   out_nxt;
  upd_t        upd;
  logic [15:0] rd_src;
  logic [15:0] rd_dst;
  logic        acc;
  logic [3:0]  src_idx;
  logic [3:0]  dst_idx;

  // accept while output slot is free or being drained
  assign in_stall  = out_valid_r & out_stall;
  assign acc       = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign src_idx = in_data.instruction_word[7:4];
  assign dst_idx = in_data.instruction_word[3:0];
  assign rd_src  = (src_idx == REG_ZERO) ? 16'd0 : regs_r[src_idx];
  assign rd_dst  = (dst_idx == REG_ZERO) ? 16'd0 : regs_r[dst_idx];

  p16cpu_exec u_exec (
    .item     (in_data),
    .rd_src   (rd_src),
    .rd_dst   (rd_dst),
    .pc       (regs_r[15]),
    .flags    (flags_r),
    .ret_pc   (ret_pc_r),
    .saved_st (saved_st_r),
    .pend     (pend_r),
    .irq_vec  (irq_vec_r),
    .upd      (upd)
  );

  // result beat
  always_comb begin
    out_nxt.access_kind        = upd.kind;
    out_nxt.access_address     = upd.addr;
    out_nxt.write_data         = upd.wdata;
    out_nxt.next_fetch_address = upd.restart ? rst_vec_r : upd.pc;
    out_nxt.status_word        = upd.restart ? 8'd0 : upd.flags;
    out_nxt.awaiting_load      = upd.restart ? 1'b0 : upd.pend[4];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_vec_r <= 16'd0;
      irq_vec_r <= 16'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RESET_VEC) rst_vec_r <= cfg_wdata;
      if (cfg_index == CFG_IRQ_VEC)   irq_vec_r <= cfg_wdata;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i < 16; i++) regs_r[i] <= 16'd0;
      flags_r    <= 8'd0;
      ret_pc_r   <= 16'd0;
      saved_st_r <= 8'd0;
      pend_r     <= 5'd0;
    end else if (acc) begin
      if (upd.restart) begin
        for (int i = 1; i < 15; i++) regs_r[i] <= 16'd0;
        regs_r[15] <= rst_vec_r;
        flags_r    <= 8'd0;
        ret_pc_r   <= 16'd0;
        saved_st_r <= 8'd0;
        pend_r     <= 5'd0;
      end else begin
        if (upd.reg_we && upd.reg_idx != REG_ZERO && upd.reg_idx != REG_PC)
          regs_r[upd.reg_idx] <= upd.reg_val;
        regs_r[15] <= upd.pc;
        flags_r    <= upd.flags;
        pend_r     <= upd.pend;
        if (upd.save_we) begin
          ret_pc_r   <= upd.save_pc;
          saved_st_r <= upd.save_st;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // no accept while the output beat is held
  a_no_acc_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !acc) else $error("accept while held");
  // an accept always yields a valid beat next cycle
  a_acc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid) else $error("missing result beat");
  // a read access beat always shows a pending load
  a_pend_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.access_kind == ACC_READ) |-> out_data.awaiting_load)
    else $error("read without pending load");
  // state holds when nothing is accepted
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(flags_r) && $stable(pend_r)) else $error("state moved");
`endif

endmodule
